[rtl/sme_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;
  localparam int MaxTasks  = 1024;
  localparam int MaxAgents = 64;
  localparam int TaskAw    = $clog2(MaxTasks);
  localparam int AgentAw   = $clog2(MaxAgents);
  localparam int TimeW     = 32;
  localparam int SpeedW    = 16;
  localparam int QuotW     = 40;
  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef enum logic [2:0] {
    FUNC_START  = 3'd0,
    FUNC_SPEED  = 3'd1,
    FUNC_LENGTH = 3'd2,
    FUNC_DEP    = 3'd3,
    FUNC_SCHED  = 3'd4,
    FUNC_FINISH = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_DIV,
    ST_WRITE,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

[rtl/sme_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module sme_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/schedule_makespan_evaluator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Contents
// s_axis    in         tdata: func, task_index, agent_index, dep_task_index,
//                      speed_sample, length_sample
// m_axis    out        tdata: time_value; tuser: result_kind, overflow, zero_speed
// Load and finish transactions are handled in the idle state; a dependency also
// passes the read state; a schedule the read, divide (one-bit-a-cycle divider),
// write and output states. After reset and each start transaction a clearing pass
// sweeps the finish-time and agent free-time RAMs; no input is taken meanwhile.
// While a result waits on m_axis, no input transaction is taken.
module schedule_makespan_evaluator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // func, task_index, agent_index,
                                          // dep_task_index, speed_sample,
                                          // length_sample, zero fill
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // time_value
  output logic [2:0]       m_axis_tuser   // result_kind, overflow, zero_speed
);
  localparam int TW = sme_pkg::TaskAw;
  localparam int AW = sme_pkg::AgentAw;
  localparam int DW = 5;
  localparam int QW = sme_pkg::QuotW;

  sme_pkg::state_t state, state_next;

  logic [2:0]  in_func;
  logic [9:0]  in_task, in_dep;
  logic [5:0]  in_agent;
  logic [15:0] in_speed;
  logic [31:0] in_length;
  assign in_func   = s_axis_tdata[2:0];
  assign in_task   = s_axis_tdata[12:3];
  assign in_agent  = s_axis_tdata[18:13];
  assign in_dep    = s_axis_tdata[28:19];
  assign in_speed  = s_axis_tdata[44:29];
  assign in_length = s_axis_tdata[76:45];

  logic in_task_ok, in_agent_ok, in_dep_ok;
  assign in_task_ok  = 32'(in_task) < 32'(sme_pkg::MaxTasks);
  assign in_agent_ok = 32'(in_agent) < 32'(sme_pkg::MaxAgents);
  assign in_dep_ok   = 32'(in_dep) < 32'(sme_pkg::MaxTasks);

  logic          accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  logic [TW-1:0] clr_cnt;
  logic [TW:0]   clr_left;
  logic          is_dep;
  logic [TW-1:0] task_r;
  logic [AW-1:0] agent_r;
  logic          task_ok, agent_ok;
  logic [31:0]   dep_latest, run_makespan;
  logic          run_overflow;
  logic [31:0]   begin_t;
  logic [QW-1:0] quot;
  logic [16:0]   rem;
  logic [QW-1:0] dividend;
  logic [15:0]   divisor;
  logic [DW:0]   div_cnt;
  logic [31:0]   done_t;
  logic          ovf, zspd;

  logic [15:0] spd_rd;
  logic [31:0] len_rd, free_rd, fin_rd;
  logic        spd_we, len_we, free_we, fin_we;
  logic [AW-1:0] spd_wa, free_wa, agent_ra;
  logic [TW-1:0] len_wa, fin_wa, task_ra, fin_ra;
  logic [31:0]   free_wd, fin_wd;

  sme_ram #(.Width(16), .Depth(sme_pkg::MaxAgents)) u_speed (
    .clk, .we(spd_we), .waddr(spd_wa), .wdata(in_speed), .raddr(agent_ra), .rdata(spd_rd));
  sme_ram #(.Width(32), .Depth(sme_pkg::MaxTasks)) u_length (
    .clk, .we(len_we), .waddr(len_wa), .wdata(in_length), .raddr(task_ra), .rdata(len_rd));
  sme_ram #(.Width(32), .Depth(sme_pkg::MaxAgents)) u_free (
    .clk, .we(free_we), .waddr(free_wa), .wdata(free_wd), .raddr(agent_ra), .rdata(free_rd));
  sme_ram #(.Width(32), .Depth(sme_pkg::MaxTasks)) u_finish (
    .clk, .we(fin_we), .waddr(fin_wa), .wdata(fin_wd), .raddr(fin_ra), .rdata(fin_rd));

  assign agent_ra = in_agent[AW-1:0];
  assign task_ra  = in_task[TW-1:0];
  assign fin_ra   = in_dep[TW-1:0];

  logic clearing;
  assign clearing = (state == sme_pkg::ST_CLEAR);

  assign spd_we  = accept && (in_func == sme_pkg::FUNC_SPEED) && in_agent_ok;
  assign spd_wa  = in_agent[AW-1:0];
  assign len_we  = accept && (in_func == sme_pkg::FUNC_LENGTH) && in_task_ok;
  assign len_wa  = in_task[TW-1:0];
  assign free_we = clearing || (state == sme_pkg::ST_WRITE && agent_ok);
  assign free_wa = clearing ? clr_cnt[AW-1:0] : agent_r;
  assign free_wd = clearing ? '0 : done_t;
  assign fin_we  = clearing || (state == sme_pkg::ST_WRITE && task_ok);
  assign fin_wa  = clearing ? clr_cnt : task_r;
  assign fin_wd  = clearing ? '0 : done_t;

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  logic out_load;
  assign out_load = (state == sme_pkg::ST_OUT && out_free) ||
                    (accept && in_func == sme_pkg::FUNC_FINISH);

  always_comb begin
    s_axis_tready = 1'b0;
    case (state)
      sme_pkg::ST_IDLE: s_axis_tready = out_free;
      default:          s_axis_tready = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      sme_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_func)
            sme_pkg::FUNC_START:  state_next = sme_pkg::ST_CLEAR;
            sme_pkg::FUNC_DEP,
            sme_pkg::FUNC_SCHED:  state_next = sme_pkg::ST_READ;
            default:              state_next = sme_pkg::ST_IDLE;
          endcase
        end
      end
      sme_pkg::ST_CLEAR: if (clr_left == (TW+1)'(1)) state_next = sme_pkg::ST_IDLE;
      sme_pkg::ST_READ:  state_next = is_dep ? sme_pkg::ST_IDLE : sme_pkg::ST_DIV;
      sme_pkg::ST_DIV:   if (div_cnt == '0) state_next = sme_pkg::ST_WRITE;
      sme_pkg::ST_WRITE: state_next = sme_pkg::ST_OUT;
      sme_pkg::ST_OUT:   if (out_free) state_next = sme_pkg::ST_IDLE;
      default:           state_next = sme_pkg::ST_IDLE;
    endcase
  end

  logic [32:0] sum;
  logic [31:0] dur;
  logic        dur_ovf;
  logic [16:0] rem_sh;
  always_comb begin
    dur_ovf = zspd || (quot[QW-1:32] != '0);
    dur     = dur_ovf ? sme_pkg::TimeMax : quot[31:0];
    sum     = {1'b0, begin_t} + {1'b0, dur};
    rem_sh  = {rem[15:0], dividend[QW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sme_pkg::ST_CLEAR;
      clr_cnt       <= '0;
      clr_left      <= (TW+1)'(sme_pkg::MaxTasks);
      dep_latest    <= '0;
      run_makespan  <= '0;
      run_overflow  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready && !out_load) m_axis_tvalid <= 1'b0;
      case (state)
        sme_pkg::ST_IDLE: begin
          if (accept) begin
            is_dep   <= (in_func == sme_pkg::FUNC_DEP);
            task_r   <= in_task[TW-1:0];
            agent_r  <= in_agent[AW-1:0];
            agent_ok <= in_agent_ok;
            task_ok  <= (in_func == sme_pkg::FUNC_DEP) ? in_dep_ok : in_task_ok;
            case (in_func)
              sme_pkg::FUNC_START: begin
                clr_cnt      <= '0;
                clr_left     <= (TW+1)'(sme_pkg::MaxTasks);
                dep_latest   <= '0;
                run_makespan <= '0;
                run_overflow <= 1'b0;
              end
              sme_pkg::FUNC_FINISH: begin
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {8'd0, run_makespan[31:8]};
                m_axis_tuser  <= {1'b0, run_overflow, 1'b1};
              end
              default: ;
            endcase
          end
        end
        sme_pkg::ST_CLEAR: begin
          clr_cnt  <= clr_cnt + 1'b1;
          clr_left <= clr_left - 1'b1;
        end
        sme_pkg::ST_READ: begin
          if (is_dep) begin
            if (task_ok && fin_rd > dep_latest) dep_latest <= fin_rd;
          end else begin
            logic [15:0] s;
            logic [31:0] l, f;
            s = agent_ok ? spd_rd : 16'd0;
            l = task_ok ? len_rd : 32'd0;
            f = agent_ok ? free_rd : 32'd0;
            zspd     <= (s == 16'd0);
            divisor  <= s;
            dividend <= {l, 8'd0};
            rem      <= '0;
            quot     <= '0;
            div_cnt  <= (DW+1)'(QW);
            begin_t  <= (dep_latest > f) ? dep_latest : f;
          end
        end
        sme_pkg::ST_DIV: begin
          if (div_cnt != '0) begin
            dividend <= {dividend[QW-2:0], 1'b0};
            if (rem_sh >= {1'b0, divisor}) begin
              rem  <= rem_sh - {1'b0, divisor};
              quot <= {quot[QW-2:0], 1'b1};
            end else begin
              rem  <= rem_sh;
              quot <= {quot[QW-2:0], 1'b0};
            end
            div_cnt <= div_cnt - 1'b1;
          end else begin
            done_t <= sum[32] ? sme_pkg::TimeMax : sum[31:0];
            ovf    <= dur_ovf || sum[32];
          end
        end
        sme_pkg::ST_WRITE: begin
          dep_latest <= '0;
          if (done_t > run_makespan) run_makespan <= done_t;
          if (ovf) run_overflow <= 1'b1;
        end
        sme_pkg::ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= done_t;
            m_axis_tuser  <= {zspd, ovf, 1'b0};
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
